// ----- src/nmea_rmc_sentence_parser_assert.svh -----
// Assertion macros for the RMC parser. Expect clk and arst_n in scope.
`ifndef NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH

// cond must hold in the same cycle whenever trig holds
`define NRMC_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// cond must hold in the cycle after trig
`define NRMC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- src/nrmc_pkg.sv -----
`timescale 1ns / 1ps
package nrmc_pkg;

	localparam int FIELD_COUNT = 11;
	localparam int FIELD_IDX_W = 4;
	localparam logic [2:0] FRAC_DIGITS = 3'd4;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
	localparam logic [31:0] DATE_MAX = 32'd999999;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [3:0] TOKENS_FULL = 4'd12;
	localparam logic [3:0] TOKEN_IDX_MAX = 4'd15;
	localparam logic [2:0] TAG_LEN = 3'd6;
	localparam logic [2:0] TAG_POS_MAX = 3'd7;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_TAG = 2'd1,
		ST_SHORT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_FIXED = 2'd0,
		KIND_DATE  = 2'd1,
		KIND_CHAR  = 2'd2
	} field_kind_t;

	typedef struct packed {
		status_t     status_code;
		logic [31:0] time_value;
		logic [7:0]  fix_status;
		logic [31:0] latitude;
		logic [7:0]  lat_hemisphere;
		logic [31:0] longitude;
		logic [7:0]  lon_hemisphere;
		logic [31:0] ground_speed;
		logic [31:0] track_course;
		logic [19:0] date_value;
		logic [31:0] magnetic_variation;
		logic [7:0]  variation_direction;
	} rmc_fields_t;

	function automatic field_kind_t field_kind(input logic [FIELD_IDX_W-1:0] idx);
		field_kind_t k;
		case (idx)
			4'd1, 4'd3, 4'd5, 4'd10: k = KIND_CHAR;
			4'd8:                    k = KIND_DATE;
			default:                 k = KIND_FIXED;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] tag_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h24; // $
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h50; // P
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4D; // M
			3'd5:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] pow_ten(input logic [2:0] n);
		logic [23:0] p;
		case (n)
			3'd0:    p = 24'd1;
			3'd1:    p = 24'd10;
			3'd2:    p = 24'd100;
			3'd3:    p = 24'd1000;
			3'd4:    p = 24'd10000;
			3'd5:    p = 24'd100000;
			3'd6:    p = 24'd1000000;
			default: p = 24'd10000000;
		endcase
		return p;
	endfunction

endpackage

// ----- src/nrmc_scale.sv -----
`timescale 1ns / 1ps
module nrmc_scale (
	input  logic [31:0] acc,
	input  logic [2:0]  shift,
	output logic [31:0] scaled
);

	logic [55:0] product;

	always_comb begin
		product = {24'd0, acc} * {32'd0, nrmc_pkg::pow_ten(shift)};
		scaled = (|product[55:32]) ? nrmc_pkg::SAT32 : product[31:0];
	end

endmodule

// ----- src/nrmc_line_parser.sv -----
`timescale 1ns / 1ps
module nrmc_line_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data,
	output nrmc_pkg::rmc_fields_t result
);

	logic [3:0]  idx_q, idx_d, idx_end;
	logic [2:0]  tag_pos_q, tag_pos_d;
	logic        tag_ok_q, tag_ok_d, tag_ok_end;
	logic        between_q, between_d;
	logic [31:0] acc_q, acc_d;
	logic [2:0]  frac_q, frac_d;
	logic        point_q, point_d;
	logic        stop_q, stop_d;
	logic [31:0] fld_q [nrmc_pkg::FIELD_COUNT];
	logic [31:0] fld_d [nrmc_pkg::FIELD_COUNT];
	logic [31:0] fld_end [nrmc_pkg::FIELD_COUNT];
	logic [31:0] scaled;
	logic [2:0]  shift;

	function automatic logic [31:0] dec_mac(input logic [31:0] a, input logic [3:0] d,
		input logic [31:0] cap);
		logic [35:0] t;
		t = ({4'd0, a} << 3) + ({4'd0, a} << 1) + {32'd0, d};
		return (t > {4'd0, cap}) ? cap : t[31:0];
	endfunction

	assign shift = nrmc_pkg::FRAC_DIGITS - frac_q;

	nrmc_scale u_scale (
		.acc    (acc_q),
		.shift  (shift),
		.scaled (scaled)
	);

	always_comb begin
		logic                             te_active;
		logic                             in_field;
		logic [nrmc_pkg::FIELD_IDX_W-1:0] fi;
		nrmc_pkg::field_kind_t            kind;
		logic                             is_digit;
		logic [31:0]                      c_acc;
		logic [2:0]                       c_frac;
		logic                             c_point;
		logic                             c_stop;

		te_active = !between_q;
		in_field = (idx_q != 4'd0) && (idx_q <= 4'(nrmc_pkg::FIELD_COUNT));
		fi = idx_q - 4'd1;
		kind = nrmc_pkg::field_kind(fi);
		is_digit = (data >= nrmc_pkg::CH_ZERO) && (data <= nrmc_pkg::CH_NINE);

		// effect of closing the current token
		fld_end = fld_q;
		if (te_active && in_field) begin
			for (int i = 0; i < nrmc_pkg::FIELD_COUNT; i++) begin
				if (4'(i) == fi) begin
					case (kind)
						nrmc_pkg::KIND_FIXED: fld_end[i] = scaled;
						nrmc_pkg::KIND_DATE:  fld_end[i] = acc_q;
						default:              fld_end[i] = fld_q[i];
					endcase
				end
			end
		end
		tag_ok_end = tag_ok_q &&
			!(te_active && idx_q == 4'd0 && tag_pos_q != nrmc_pkg::TAG_LEN);
		idx_end = (te_active && idx_q != nrmc_pkg::TOKEN_IDX_MAX) ? idx_q + 4'd1 : idx_q;

		// result for a newline
		result = '0;
		if (idx_end == 4'd0 || !tag_ok_end) begin
			result.status_code = nrmc_pkg::ST_BAD_TAG;
		end else if (idx_end < nrmc_pkg::TOKENS_FULL) begin
			result.status_code = nrmc_pkg::ST_SHORT;
		end else begin
			result.status_code         = nrmc_pkg::ST_OK;
			result.time_value          = fld_end[0];
			result.fix_status          = fld_end[1][7:0];
			result.latitude            = fld_end[2];
			result.lat_hemisphere      = fld_end[3][7:0];
			result.longitude           = fld_end[4];
			result.lon_hemisphere      = fld_end[5][7:0];
			result.ground_speed        = fld_end[6];
			result.track_course        = fld_end[7];
			result.date_value          = fld_end[8][19:0];
			result.magnetic_variation  = fld_end[9];
			result.variation_direction = fld_end[10][7:0];
		end

		idx_d = idx_q;
		tag_pos_d = tag_pos_q;
		tag_ok_d = tag_ok_q;
		between_d = between_q;
		acc_d = acc_q;
		frac_d = frac_q;
		point_d = point_q;
		stop_d = stop_q;
		fld_d = fld_q;

		c_acc = between_q ? 32'd0 : acc_q;
		c_frac = between_q ? 3'd0 : frac_q;
		c_point = between_q ? 1'b0 : point_q;
		c_stop = between_q ? 1'b0 : stop_q;

		if (step) begin
			if (data == nrmc_pkg::CH_NEWLINE) begin
				idx_d = 4'd0;
				tag_pos_d = 3'd0;
				tag_ok_d = 1'b1;
				between_d = 1'b1;
				acc_d = 32'd0;
				frac_d = 3'd0;
				point_d = 1'b0;
				stop_d = 1'b0;
				for (int i = 0; i < nrmc_pkg::FIELD_COUNT; i++) begin
					fld_d[i] = 32'd0;
				end
			end else if (data == nrmc_pkg::CH_COMMA) begin
				idx_d = idx_end;
				tag_ok_d = tag_ok_end;
				between_d = 1'b1;
				fld_d = fld_end;
			end else begin
				between_d = 1'b0;
				if (between_q && in_field && kind == nrmc_pkg::KIND_CHAR) begin
					for (int i = 0; i < nrmc_pkg::FIELD_COUNT; i++) begin
						if (4'(i) == fi) begin
							fld_d[i] = {24'd0, data};
						end
					end
				end
				if (idx_q == 4'd0) begin
					if (tag_pos_q >= nrmc_pkg::TAG_LEN || data != nrmc_pkg::tag_char(tag_pos_q)) begin
						tag_ok_d = 1'b0;
					end
					if (tag_pos_q != nrmc_pkg::TAG_POS_MAX) begin
						tag_pos_d = tag_pos_q + 3'd1;
					end
				end else if (in_field && !c_stop) begin
					case (kind)
						nrmc_pkg::KIND_FIXED: begin
							if (is_digit) begin
								if (!c_point) begin
									c_acc = dec_mac(c_acc, data[3:0], nrmc_pkg::SAT32);
								end else if (c_frac < nrmc_pkg::FRAC_DIGITS) begin
									c_acc = dec_mac(c_acc, data[3:0], nrmc_pkg::SAT32);
									c_frac = c_frac + 3'd1;
								end
							end else if (data == nrmc_pkg::CH_POINT && !c_point) begin
								c_point = 1'b1;
							end else begin
								c_stop = 1'b1;
							end
						end
						nrmc_pkg::KIND_DATE: begin
							if (is_digit) begin
								c_acc = dec_mac(c_acc, data[3:0], nrmc_pkg::DATE_MAX);
							end else begin
								c_stop = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				acc_d = c_acc;
				frac_d = c_frac;
				point_d = c_point;
				stop_d = c_stop;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 4'd0;
			tag_pos_q <= 3'd0;
			tag_ok_q <= 1'b1;
			between_q <= 1'b1;
			acc_q <= 32'd0;
			frac_q <= 3'd0;
			point_q <= 1'b0;
			stop_q <= 1'b0;
			for (int i = 0; i < nrmc_pkg::FIELD_COUNT; i++) begin
				fld_q[i] <= 32'd0;
			end
		end else begin
			idx_q <= idx_d;
			tag_pos_q <= tag_pos_d;
			tag_ok_q <= tag_ok_d;
			between_q <= between_d;
			acc_q <= acc_d;
			frac_q <= frac_d;
			point_q <= point_d;
			stop_q <= stop_d;
			fld_q <= fld_d;
		end
	end

endmodule

// ----- src/nmea_rmc_sentence_parser.sv -----
`timescale 1ns / 1ps
// NMEA 0183 RMC parser: one ASCII byte per word on the byte channel; a newline
// word yields one result word carrying status code and the decoded fields.
// Every byte is first registered in the input register; the tokenizer state and the
// field store then update from it, so a byte can be taken every cycle while the
// byte channel does not stall. A result is loaded into the result register as its
// newline leaves the input register. The byte channel stalls only while a newline
// sits in the input register and the result register still holds a stalled result.
`include "nmea_rmc_sentence_parser_assert.svh"
module nmea_rmc_sentence_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status_code,
	output logic [31:0] time_value,
	output logic [7:0]  fix_status,
	output logic [31:0] latitude,
	output logic [7:0]  lat_hemisphere,
	output logic [31:0] longitude,
	output logic [7:0]  lon_hemisphere,
	output logic [31:0] ground_speed,
	output logic [31:0] track_course,
	output logic [19:0] date_value,
	output logic [31:0] magnetic_variation,
	output logic [7:0]  variation_direction
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  out_free;
	logic                  advance;
	logic                  out_load;
	logic                  accept;
	logic                  result_valid_q;
	nrmc_pkg::rmc_fields_t parsed;
	nrmc_pkg::rmc_fields_t result_q;
	logic                  pend_newline;
	logic                  err_shown;
	logic                  err_clear;

	assign out_free = !result_valid_q || !result_stall;
	assign advance = valid_s1 && (byte_s1 != nrmc_pkg::CH_NEWLINE || out_free);
	assign out_load = advance && byte_s1 == nrmc_pkg::CH_NEWLINE;
	assign byte_stall = valid_s1 && !advance;
	assign accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
		end
	end

	nrmc_line_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data   (byte_s1),
		.result (parsed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= parsed;
		end
	end

	assign result_valid        = result_valid_q;
	assign status_code         = result_q.status_code;
	assign time_value          = result_q.time_value;
	assign fix_status          = result_q.fix_status;
	assign latitude            = result_q.latitude;
	assign lat_hemisphere      = result_q.lat_hemisphere;
	assign longitude           = result_q.longitude;
	assign lon_hemisphere      = result_q.lon_hemisphere;
	assign ground_speed        = result_q.ground_speed;
	assign track_course        = result_q.track_course;
	assign date_value          = result_q.date_value;
	assign magnetic_variation  = result_q.magnetic_variation;
	assign variation_direction = result_q.variation_direction;

	assign pend_newline = valid_s1 && byte_s1 == nrmc_pkg::CH_NEWLINE;
	assign err_shown = result_valid_q && result_q.status_code != nrmc_pkg::ST_OK;
	assign err_clear = result_q.time_value == 32'd0 && result_q.date_value == 20'd0;

	`NRMC_ASSERT_NEXT(a_load_shows, out_load, result_valid_q, "result not shown after newline")
	`NRMC_ASSERT_NOW(a_stall_needs_byte, byte_stall, pend_newline, "stall without newline")
	`NRMC_ASSERT_NOW(a_error_zero, err_shown, err_clear, "error result carries data")
	`NRMC_ASSERT_NOW(a_date_range, result_valid_q, result_q.date_value <= 20'd999999, "date over max")

endmodule
